// File: hdl/aisp_pkg.sv
// Shared types, port codes and constants for the arcade I/O port block.
`default_nettype none

package aisp_pkg;

  // Request operation codes.
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_CONTROL = 2'd2;

  // Port numbers decoded on reads.
  localparam logic [7:0] PORT_IN0    = 8'd0;
  localparam logic [7:0] PORT_IN1    = 8'd1;
  localparam logic [7:0] PORT_IN2    = 8'd2;
  localparam logic [7:0] PORT_SHIFT_RD = 8'd3;

  // Port numbers decoded on writes.
  localparam logic [7:0] PORT_SHIFT_AMT  = 8'd2;
  localparam logic [7:0] PORT_SOUND_A    = 8'd3;
  localparam logic [7:0] PORT_SHIFT_DATA = 8'd4;
  localparam logic [7:0] PORT_SOUND_B    = 8'd5;

  // Control identifiers.
  localparam logic [2:0] CTRL_ONE_PLAYER = 3'd0;
  localparam logic [2:0] CTRL_TWO_PLAYER = 3'd1;
  localparam logic [2:0] CTRL_COIN       = 3'd2;
  localparam logic [2:0] CTRL_FIRE       = 3'd3;
  localparam logic [2:0] CTRL_RIGHT      = 3'd4;
  localparam logic [2:0] CTRL_LEFT       = 3'd5;

  // Fixed read values and latch constants.
  localparam logic [7:0] PORT0_VALUE   = 8'h0F;
  localparam logic [7:0] PORT2_VALUE   = 8'h00;
  localparam logic [7:0] DEFAULT_VALUE = 8'hFF;
  localparam logic [7:0] LATCH_FIXED   = 8'h08;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] port_number;
    logic [7:0] write_value;
    logic [2:0] control_id;
    logic       pressed;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [8:0] sound_start;
    logic       ufo_stop;
  } result_t;

  // Latch bit that belongs to each control.
  function automatic logic [7:0] control_mask(input logic [2:0] id);
    logic [7:0] m;
    case (id)
      CTRL_ONE_PLAYER: m = 8'h04;
      CTRL_TWO_PLAYER: m = 8'h02;
      CTRL_COIN:       m = 8'h01;
      CTRL_FIRE:       m = 8'h10;
      CTRL_RIGHT:      m = 8'h40;
      CTRL_LEFT:       m = 8'h20;
      default:         m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: hdl/aisp_core.sv
// Port state registers and the single-pass read, write and control logic.
`default_nettype none

module aisp_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_fire,
  input  wire aisp_pkg::item_t  item,
  output aisp_pkg::result_t     result
);
  import aisp_pkg::*;

  logic [7:0] shift_high_r, shift_high_nxt;
  logic [7:0] shift_low_r, shift_low_nxt;
  logic [2:0] shift_amount_r, shift_amount_nxt;
  logic [7:0] sound_a_r, sound_a_nxt;
  logic [7:0] sound_b_r, sound_b_nxt;
  logic [7:0] latch_r, latch_nxt;

  logic [15:0] shifted;
  logic [7:0]  rise_a;
  logic [7:0]  rise_b;
  logic [7:0]  mask;
  logic        is_write;

  assign shifted  = {shift_high_r, shift_low_r} << shift_amount_r;
  assign rise_a   = item.write_value & ~sound_a_r;
  assign rise_b   = item.write_value & ~sound_b_r;
  assign mask     = control_mask(item.control_id);
  assign is_write = (item.opcode == OP_WRITE);

  // Result for the request in the input register.
  always_comb begin
    result = '0;
    if (item.opcode == OP_READ) begin
      case (item.port_number)
        PORT_IN0:      result.read_data = PORT0_VALUE;
        PORT_IN1:      result.read_data = latch_r;
        PORT_IN2:      result.read_data = PORT2_VALUE;
        PORT_SHIFT_RD: result.read_data = shifted[15:8];
        default:       result.read_data = DEFAULT_VALUE;
      endcase
    end else if (is_write) begin
      case (item.port_number)
        PORT_SOUND_A: begin
          result.sound_start[3:0] = rise_a[3:0];
          result.ufo_stop         = sound_a_r[0] & ~item.write_value[0];
        end
        PORT_SOUND_B: result.sound_start[8:4] = rise_b[4:0];
        default: ;
      endcase
    end
  end

  // Next state, applied only when the request moves on.
  always_comb begin
    shift_high_nxt   = shift_high_r;
    shift_low_nxt    = shift_low_r;
    shift_amount_nxt = shift_amount_r;
    sound_a_nxt      = sound_a_r;
    sound_b_nxt      = sound_b_r;
    latch_nxt        = latch_r;
    if (is_write) begin
      case (item.port_number)
        PORT_SHIFT_AMT: shift_amount_nxt = item.write_value[2:0];
        PORT_SOUND_A:   sound_a_nxt = item.write_value;
        PORT_SHIFT_DATA: begin
          shift_low_nxt  = shift_high_r;
          shift_high_nxt = item.write_value;
        end
        PORT_SOUND_B:   sound_b_nxt = item.write_value;
        default: ;
      endcase
    end else if (item.opcode == OP_CONTROL) begin
      latch_nxt = (item.pressed ? (latch_r | mask) : (latch_r & ~mask)) | LATCH_FIXED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_high_r   <= '0;
      shift_low_r    <= '0;
      shift_amount_r <= '0;
      sound_a_r      <= '0;
      sound_b_r      <= '0;
      latch_r        <= LATCH_FIXED;
    end else if (item_fire) begin
      shift_high_r   <= shift_high_nxt;
      shift_low_r    <= shift_low_nxt;
      shift_amount_r <= shift_amount_nxt;
      sound_a_r      <= sound_a_nxt;
      sound_b_r      <= sound_b_nxt;
      latch_r        <= latch_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // The fixed latch bit never drops once out of reset.
  a_latch_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (latch_r & LATCH_FIXED) == LATCH_FIXED)
    else $error("control latch lost its fixed bit");

  // A stop pulse and a ufo start pulse cannot come from the same write.
  a_stop_vs_start: assert property (@(posedge clk) disable iff (!rst_n)
    result.ufo_stop |-> !result.sound_start[0])
    else $error("ufo start and stop in the same result");

  // Only writes raise sound pulses.
  a_pulses_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    !is_write |-> (result.sound_start == '0 && !result.ufo_stop))
    else $error("sound pulse on a non-write request");

  // A shift push moves the high byte into the low byte.
  a_shift_push: assert property (@(posedge clk) disable iff (!rst_n)
    (item_fire && is_write && item.port_number == PORT_SHIFT_DATA)
      |=> shift_low_r == $past(shift_high_r))
    else $error("shift push lost the high byte");
`endif

endmodule

`default_nettype wire

// File: hdl/arcade_io_shifter_sound_ports.sv
// Top level of the arcade I/O port block: input register, core and result register.
//
// Usage: each request on the in_ channel is a port read, a port write or a
// control press/release event. Every request gives exactly one result on the
// out_ channel: read_data for reads, sound start pulses and the ufo stop pulse
// for writes to the sound ports, and zeros otherwise.
// Both channels move a request when valid is high and stall is low.
// A request accepted on the in_ channel is held in the input register, passes
// the core logic into the result register once that register can load, and is
// offered on out_valid from then on.
// Throughput: one request per cycle while out_stall stays low; the core logic is
// one level of port decode, an 8-position byte shifter and edge compares.
// The input register keeps accepting while a finished result waits, and
// in_stall rises only when both registers are full and out_stall is high.
// Reset clears both valid flags, the shift pair, the shift amount and the
// sound banks, and sets the control latch to its fixed bit.
`default_nettype none

module arcade_io_shifter_sound_ports (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_opcode,
  input  wire logic [7:0] in_port_number,
  input  wire logic [7:0] in_write_value,
  input  wire logic [2:0] in_control_id,
  input  wire logic       in_pressed,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_data,
  output logic [8:0]      out_sound_start,
  output logic            out_ufo_stop
);
  import aisp_pkg::*;

  logic    in_valid_r, in_valid_nxt;
  item_t   in_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t core_res;
  logic    out_adv;
  logic    core_fire;
  logic    in_take;

  // The result register can load when empty or being drained.
  assign out_adv   = !out_valid_r || !out_stall;
  assign core_fire = in_valid_r && out_adv;
  assign in_stall  = in_valid_r && !out_adv;
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt  = in_stall ? in_valid_r : in_valid;
    out_valid_nxt = out_adv ? in_valid_r : out_valid_r;
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.opcode      <= in_opcode;
      in_item_r.port_number <= in_port_number;
      in_item_r.write_value <= in_write_value;
      in_item_r.control_id  <= in_control_id;
      in_item_r.pressed     <= in_pressed;
    end
    if (core_fire) begin
      out_res_r <= core_res;
    end
  end

  aisp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (core_fire),
    .item      (in_item_r),
    .result    (core_res)
  );

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_res_r.read_data;
  assign out_sound_start = out_res_r.sound_start;
  assign out_ufo_stop    = out_res_r.ufo_stop;

endmodule

`default_nettype wire
